>>> sv/proportional_share_slice_scheduler_top_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef PROPORTIONAL_SHARE_SLICE_SCHEDULER_TOP_MACROS_SVH
`define PROPORTIONAL_SHARE_SLICE_SCHEDULER_TOP_MACROS_SVH

// condition and consequence in the same cycle
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss assertion failed");

// consequence in the cycle after the condition
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss assertion failed");

`endif

>>> sv/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int KIND_W    = 2;
    localparam int ID_W      = 16;
    localparam int BURST_W   = 16;
    localparam int WEIGHT_W  = 8;
    localparam int TOTAL_W   = 12;
    localparam int QUANT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int PROD_W    = WEIGHT_W + QUANT_W;
    localparam int DIVC_W    = $clog2(PROD_W);
    localparam int ENTRY_W   = ID_W + BURST_W + WEIGHT_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GRANTED  = 2'd0,
        STATUS_FINISHED = 2'd1,
        STATUS_INVALID  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

>>> sv/pss_ram.sv
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/proportional_share_slice_scheduler_top.sv
`timescale 1ns / 1ps
`include "proportional_share_slice_scheduler_top_macros.svh"

// Proportional-share slice scheduler. A table of 16 tasks (id, remaining burst, weight) sits
// in one synchronous RAM; per-entry finished flags, the total weight, the current time and the
// round-robin pointer are registers. Clear and load items are taken back to back. A next item
// walks the finished flags one entry per cycle from the round-robin pointer, reads the chosen
// entry, forms weight * quantum in one multiply and divides it by the total weight with a
// restoring divider that produces one quotient bit per cycle. While a next item is in flight
// the input side is stalled. The result waits in an output register, so clear and load items
// are taken while it is unclaimed. Configuration writes are always ready and must only be
// issued while the block is idle.
module proportional_share_slice_scheduler_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pss_pkg::KIND_W-1:0]            i_kind,
    input  logic [pss_pkg::IDX_W-1:0]             i_slot,
    input  logic [pss_pkg::ID_W-1:0]              i_process_id,
    input  logic [pss_pkg::BURST_W-1:0]           i_burst_time,
    input  logic [pss_pkg::WEIGHT_W-1:0]          i_weight,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [pss_pkg::STATUS_W-1:0]          o_status,
    output logic [pss_pkg::ID_W-1:0]              o_task_id,
    output logic [pss_pkg::TIME_W-1:0]            o_start_time,
    output logic [pss_pkg::TIME_W-1:0]            o_end_time,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pss_pkg::QUANT_W-1:0]           i_cfg_data
);

    import pss_pkg::*;

    // control
    t_state                 r_state, n_state;
    t_status                r_res;

    // configuration registers
    logic [QUANT_W-1:0]     r_quantum;
    logic [CNT_W-1:0]       r_task_count;

    // scheduler state
    logic [MAX_TASKS-1:0]   r_done;
    logic [TOTAL_W-1:0]     r_weight_total;
    logic [TIME_W-1:0]      r_time;
    logic [IDX_W-1:0]       r_scan;

    // per-item working registers
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_k;
    logic [CNT_W-1:0]       r_count;
    logic [ID_W-1:0]        r_id;
    logic [BURST_W-1:0]     r_rem;
    logic [WEIGHT_W-1:0]    r_weight;
    logic [PROD_W-1:0]      r_prod;       // product, then quotient as bits shift in
    logic [TOTAL_W-1:0]     r_div_rem;
    logic [DIVC_W-1:0]      r_div_cnt;

    // result register
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [ID_W-1:0]        r_task_id;
    logic [TIME_W-1:0]      r_start_time;
    logic [TIME_W-1:0]      r_end_time;

    // handshakes
    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_emit;

    // scan helpers
    logic [CNT_W-1:0]       w_count;
    logic [CNT_W-1:0]       w_pos_inc;
    logic [IDX_W-1:0]       w_pos_next;
    logic [IDX_W-1:0]       w_pos_first;
    logic [IDX_W-1:0]       w_k_last;
    logic                   w_invalid;
    logic                   w_scan_hit;
    logic                   w_scan_end;

    // divider step
    logic [TOTAL_W:0]       w_div_sh;
    logic [TOTAL_W:0]       w_div_sub;
    logic                   w_div_ge;

    // slice arithmetic
    logic [PROD_W-1:0]      w_slice;
    logic [BURST_W-1:0]     w_run;
    logic [BURST_W-1:0]     w_rem_new;
    logic [TIME_W-1:0]      w_end;

    // weight accumulation
    logic [TOTAL_W:0]       w_total_sum;
    logic [TOTAL_W-1:0]     w_total_sat;

    // table ram
    logic                   w_ram_we;
    logic [IDX_W-1:0]       w_ram_waddr;
    logic [ENTRY_W-1:0]     w_ram_wdata;
    logic [ENTRY_W-1:0]     w_ram_rdata;
    logic [ID_W-1:0]        w_rd_id;
    logic [BURST_W-1:0]     w_rd_rem;
    logic [WEIGHT_W-1:0]    w_rd_weight;

    // result fields
    logic [ID_W-1:0]        w_res_id;
    logic [TIME_W-1:0]      w_res_start;
    logic [TIME_W-1:0]      w_res_end;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_state == ST_EMIT) && w_out_free;

    // task_count above the table size acts as the table size
    assign w_count     = (r_task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : r_task_count;
    assign w_pos_inc   = CNT_W'(r_pos) + CNT_W'(1);
    assign w_pos_next  = (w_pos_inc < w_count) ? w_pos_inc[IDX_W-1:0] : '0;
    assign w_pos_first = (CNT_W'(r_scan) < w_count) ? r_scan : '0;
    assign w_k_last    = IDX_W'(r_count - CNT_W'(1));
    assign w_invalid   = (r_weight_total == '0) || (r_quantum == '0);
    assign w_scan_hit  = !r_done[r_pos];
    assign w_scan_end  = (r_k == w_k_last);

    // restoring division: one quotient bit per cycle
    assign w_div_sh  = {r_div_rem, r_prod[PROD_W-1]};
    assign w_div_sub = w_div_sh - {1'b0, r_weight_total};
    assign w_div_ge  = (w_div_sh >= {1'b0, r_weight_total});

    // zero slice is raised to one while work remains
    assign w_slice   = ((r_prod == '0) && (r_rem != '0)) ? PROD_W'(1) : r_prod;
    assign w_run     = ({{(PROD_W-BURST_W){1'b0}}, r_rem} < w_slice) ? r_rem
                                                                     : w_slice[BURST_W-1:0];
    assign w_rem_new = r_rem - w_run;
    assign w_end     = r_time + TIME_W'(w_run);

    // total weight saturates instead of wrapping
    assign w_total_sum = {1'b0, r_weight_total} + (TOTAL_W+1)'(i_weight);
    assign w_total_sat = w_total_sum[TOTAL_W] ? TOTAL_MAX : w_total_sum[TOTAL_W-1:0];

    assign {w_rd_id, w_rd_rem, w_rd_weight} = w_ram_rdata;

    // ram write port: load in idle, remaining-burst write-back on a granted slice
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_pos;
        w_ram_wdata = {r_id, w_rem_new, r_weight};
        if (r_state == ST_IDLE) begin
            w_ram_we    = w_in_acc && (i_kind == KIND_LOAD);
            w_ram_waddr = i_slot;
            w_ram_wdata = {i_process_id, i_burst_time, i_weight};
        end else if (w_emit && (r_res == STATUS_GRANTED)) begin
            w_ram_we    = 1'b1;
        end
    end

    pss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_kind == KIND_NEXT)) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (w_invalid || (w_count == '0)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_hit) begin
                    n_state = ST_MUL;
                end else if (w_scan_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_cnt == DIVC_W'(PROD_W - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result fields per outcome
    always_comb begin
        case (r_res)
            STATUS_GRANTED: begin
                w_res_id    = r_id;
                w_res_start = r_time;
                w_res_end   = w_end;
            end
            STATUS_FINISHED: begin
                w_res_id    = '0;
                w_res_start = r_time;
                w_res_end   = r_time;
            end
            default: begin
                w_res_id    = '0;
                w_res_start = '0;
                w_res_end   = '0;
            end
        endcase
    end

    // control and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_quantum      <= QUANT_W'(1);
            r_task_count   <= '0;
            r_done         <= '1;
            r_weight_total <= '0;
            r_time         <= '0;
            r_scan         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_QUANTUM:    r_quantum    <= i_cfg_data;
                    REG_TASK_COUNT: r_task_count <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                case (i_kind)
                    KIND_CLEAR: begin
                        r_done         <= '1;
                        r_weight_total <= '0;
                        r_time         <= '0;
                        r_scan         <= '0;
                    end
                    KIND_LOAD: begin
                        r_done[i_slot] <= 1'b0;
                        r_weight_total <= w_total_sat;
                    end
                    default: ;
                endcase
            end

            if (w_emit && (r_res == STATUS_GRANTED)) begin
                r_time <= w_end;
                r_scan <= w_pos_next;
                if (w_rem_new == '0) begin
                    r_done[r_pos] <= 1'b1;
                end
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item datapath and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_START: begin
                r_count <= w_count;
                r_pos   <= w_pos_first;
                r_k     <= '0;
                if (w_invalid) begin
                    r_res <= STATUS_INVALID;
                end else begin
                    r_res <= STATUS_FINISHED;
                end
            end
            ST_SCAN: begin
                if (w_scan_hit) begin
                    r_res <= STATUS_GRANTED;
                end else if (!w_scan_end) begin
                    r_pos <= w_pos_next;
                    r_k   <= r_k + IDX_W'(1);
                end
            end
            ST_MUL: begin
                r_id      <= w_rd_id;
                r_rem     <= w_rd_rem;
                r_weight  <= w_rd_weight;
                r_prod    <= PROD_W'(w_rd_weight) * PROD_W'(r_quantum);
                r_div_rem <= '0;
                r_div_cnt <= '0;
            end
            ST_DIV: begin
                r_div_rem <= w_div_ge ? w_div_sub[TOTAL_W-1:0] : w_div_sh[TOTAL_W-1:0];
                r_prod    <= {r_prod[PROD_W-2:0], w_div_ge};
                r_div_cnt <= r_div_cnt + DIVC_W'(1);
            end
            default: ;
        endcase

        if (w_emit) begin
            r_status     <= r_res;
            r_task_id    <= w_res_id;
            r_start_time <= w_res_start;
            r_end_time   <= w_res_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_task_id    = r_task_id;
    assign o_start_time = r_start_time;
    assign o_end_time   = r_end_time;

    // a new result only appears after the emit state
    `PSS_ASSERT_SAME(a_result_from_emit, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_EMIT)
    // scan never runs past the active entries
    `PSS_ASSERT_SAME(a_scan_bounded, i_clk, i_rst_n, r_state == ST_SCAN, CNT_W'(r_k) < r_count)
    // partial remainder stays below the divisor
    `PSS_ASSERT_SAME(a_div_rem_low, i_clk, i_rst_n, r_state == ST_DIV, r_div_rem < r_weight_total)
    // a loaded entry takes part in scheduling at once
    `PSS_ASSERT_NEXT(a_load_arms, i_clk, i_rst_n, w_in_acc && (i_kind == KIND_LOAD), !r_done[$past(i_slot)])

endmodule
